/* hdl/assert_macros.svh */
// Assertion macros shared by the ring load balancer RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define RLB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlb assertion failed");

// Next-cycle implication
`define RLB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlb assertion failed");

`endif

/* hdl/rlb_pkg.sv */
// Package of the ring load balancer: sizes, register codes, reset values,
// and the command and status types between controller and datapath.
// No dependencies.
`default_nettype none
package rlb_pkg;

    localparam int TANKS_DEF     = 8;
    localparam int LOAD_BITS_DEF = 32;

    localparam int IDX_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_BITS      = 16;
    localparam int HOP_BITS      = 4;
    localparam int CNT_BITS      = 5;
    localparam int COST_BITS     = 32;
    localparam int OUT_BITS      = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVER      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOP       = 2'd2;

    localparam logic [CFG_BITS-1:0] THRESHOLD_RST = 16'd60;
    localparam logic [CFG_BITS-1:0] OVER_RST      = 16'd400;
    localparam logic [HOP_BITS-1:0] HOP_RST       = 4'd5;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD,
        OP_ADD,
        OP_COPY,
        OP_WAVE,
        OP_WAVE_END,
        OP_MIN_INIT,
        OP_MIN_STEP,
        OP_REM_INIT,
        OP_REM_STEP,
        OP_SHED_INIT,
        OP_SHED_STEP,
        OP_DIV,
        OP_AMT,
        OP_REL_INIT,
        OP_REL0,
        OP_REL1,
        OP_REL2,
        OP_REL3,
        OP_REL4,
        OP_REL5,
        OP_MM_INIT,
        OP_MM_STEP,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic p_ok;
        logic wave_go;
        logic ex_nz;
        logic k_last;
        logic rem_go;
        logic shed_go;
        logic rn_nz;
        logic rel_go;
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

/* hdl/rlb_div.sv */
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// Uses no package items.
`default_nettype none
module rlb_div #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [15:0]  i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quotient
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [15:0]   r_rem;
    logic [15:0]   r_dvs;
    logic [W-1:0]  r_quo;
    logic [16:0]   w_trial;
    logic          w_fit;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            // remainder stays below the divisor, so 16 bits hold it
            r_rem <= w_fit ? 16'(w_trial - {1'b0, r_dvs}) : w_trial[15:0];
            r_quo <= {r_quo[W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

/* hdl/rlb_datapath.sv */
// Datapath of the ring load balancer: tank and scratch registers, counters,
// configuration and output registers. Executes one rlb_pkg::t_op a cycle.
// Depends on rlb_pkg and rlb_div.
`default_nettype none
module rlb_datapath #(
    parameter int TANKS     = rlb_pkg::TANKS_DEF,
    parameter int LOAD_BITS = rlb_pkg::LOAD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rlb_pkg::t_cmd                     i_cmd,
    output rlb_pkg::t_status                       o_status,
    input  wire logic [rlb_pkg::IDX_BITS-1:0]      i_tank_index,
    input  wire logic                              i_cfg_we,
    input  wire logic [rlb_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [rlb_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [rlb_pkg::COST_BITS-1:0]          o_step_cost,
    output logic [rlb_pkg::OUT_BITS-1:0]           o_max_load,
    output logic [rlb_pkg::OUT_BITS-1:0]           o_min_load
);
    localparam int W  = LOAD_BITS;
    localparam int IW = $clog2(TANKS);
    localparam int AW = LOAD_BITS + 5;
    localparam int NB = rlb_pkg::CNT_BITS;
    localparam int CB = rlb_pkg::COST_BITS;

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] x);
        return (x == IW'(TANKS - 1)) ? '0 : IW'(x + 1'b1);
    endfunction

    function automatic logic [W-1:0] f_sat(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W] ? '1 : s[W-1:0];
    endfunction

    function automatic logic [CB-1:0] f_cost(input logic [CB-1:0] c, input logic [W-1:0] a);
        logic [CB:0] s;
        s = {1'b0, c} + (CB+1)'(a);
        return s[CB] ? '1 : s[CB-1:0];
    endfunction

    function automatic logic [W-1:0] f_shed(input logic [W-1:0] v,
                                            input logic [15:0] th,
                                            input logic [15:0] ov);
        logic [32:0] ve;
        logic [32:0] d;
        ve = 33'(v);
        d  = ve - 33'(th);
        if (ve <= 33'(th))
            return '0;
        else if (ve > 33'(ov))
            return W'(d >> 1);
        else
            return W'(d);
    endfunction

    // configuration
    logic [15:0]                   r_th;
    logic [15:0]                   r_over;
    logic [rlb_pkg::HOP_BITS-1:0]  r_hop;
    logic [15:0]                   w_th;

    logic [W-1:0]    r_tank [TANKS];
    logic [W-1:0]    r_scr  [TANKS];
    logic [W-1:0]    w_up   [TANKS];
    logic [W-1:0]    w_dn   [TANKS];

    logic [rlb_pkg::IDX_BITS-1:0] r_p;
    logic [IW-1:0]   w_p;
    logic [IW-1:0]   r_a, r_b, r_s, r_k, r_mi, r_c, r_far, r_nb, r_dest, r_nxt;
    logic [NB-1:0]   r_lc, r_ex, r_j, r_i;
    logic [AW-1:0]   r_acc;
    logic [W-1:0]    r_v, r_amt, r_mx, r_mn;
    logic [W-1:0]    r_omx, r_omn;
    logic [CB-1:0]   r_moved;
    logic            r_ov;
    logic [CB-1:0]   r_cost;

    // wave terms
    logic [IW-1:0]   w_wb;
    logic [W-1:0]    w_mv;
    logic [W-1:0]    w_nb_val;
    // shift to successor
    logic [IW-1:0]   w_from, w_to;
    logic [W-1:0]    w_amt;
    // relocate terms
    logic [IW-1:0]   w_dest2;

    // divider
    logic            w_div_start;
    logic [W-1:0]    w_div_a;
    logic [15:0]     w_div_b;
    logic            w_div_done;
    logic [W-1:0]    w_div_q;
    logic [NB-1:0]   w_ex;

    assign w_th = (r_th == '0) ? 16'd1 : r_th;
    assign w_p  = r_p[IW-1:0];

    for (genvar g = 0; g < TANKS; g++) begin : g_nb
        if (g == TANKS - 1) begin : g_last
            assign w_up[g] = r_tank[g];
        end else begin : g_mid
            assign w_up[g] = r_tank[g+1];
        end
        if (g == 0) begin : g_first
            assign w_dn[g] = r_tank[g];
        end else begin : g_rest
            assign w_dn[g] = r_tank[g-1];
        end
    end

    assign w_wb     = f_inc(r_a);
    assign w_mv     = f_shed(r_scr[r_a], w_th, r_over);
    assign w_nb_val = f_sat(r_tank[w_wb], w_mv);
    assign w_dest2  = (r_nb < r_a) ? IW'(r_a - 1'b1) : r_a;

    always_comb begin
        unique case (i_cmd.op)
            rlb_pkg::OP_REL2: begin
                w_from = r_nb;
                w_amt  = r_tank[r_nb];
            end
            rlb_pkg::OP_REL5: begin
                w_from = r_dest;
                w_amt  = r_amt;
            end
            default: begin
                w_from = r_s;
                w_amt  = f_shed(r_tank[r_s], w_th, r_over);
            end
        endcase
        w_to = f_inc(w_from);
    end

    assign w_div_start = (i_cmd.op == rlb_pkg::OP_WAVE) || (i_cmd.op == rlb_pkg::OP_DIV);
    assign w_div_a     = (i_cmd.op == rlb_pkg::OP_WAVE) ? w_nb_val : r_scr[r_a];
    assign w_div_b     = (i_cmd.op == rlb_pkg::OP_WAVE) ? w_th : 16'(r_j);

    // quotient minus one, held at 31 since it only meets counts up to 16
    assign w_ex = (w_div_q == '0) ? '0 :
                  (w_div_q >= W'(32)) ? NB'(31) : NB'(w_div_q - 1'b1);

    rlb_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th   <= rlb_pkg::THRESHOLD_RST;
            r_over <= rlb_pkg::OVER_RST;
            r_hop  <= rlb_pkg::HOP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rlb_pkg::CFG_THRESHOLD: r_th   <= i_cfg_data;
                rlb_pkg::CFG_OVER:      r_over <= i_cfg_data;
                rlb_pkg::CFG_HOP:       r_hop  <= i_cfg_data[rlb_pkg::HOP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // tank loads and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TANKS; k++)
                r_tank[k] <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.op == rlb_pkg::OP_OUT)
                r_ov <= 1'b1;
            else if (r_ov && i_out_ready)
                r_ov <= 1'b0;
            unique case (i_cmd.op)
                rlb_pkg::OP_ADD: r_tank[w_p] <= f_sat(r_tank[w_p], W'(1));
                rlb_pkg::OP_SHED_STEP, rlb_pkg::OP_REL2, rlb_pkg::OP_REL5: begin
                    if (r_tank[w_from] >= w_amt) begin
                        r_tank[w_from] <= r_tank[w_from] - w_amt;
                        r_tank[w_to]   <= f_sat(r_tank[w_to], w_amt);
                    end
                end
                rlb_pkg::OP_REL0: begin
                    for (int k = 0; k < TANKS; k++)
                        if (IW'(k) >= r_far) r_tank[k] <= w_up[k];
                end
                rlb_pkg::OP_REL1: begin
                    for (int k = 0; k < TANKS; k++)
                        if (IW'(k) > r_nb) r_tank[k] <= w_dn[k];
                        else if (IW'(k) == r_nb) r_tank[k] <= r_v;
                end
                rlb_pkg::OP_REL3: begin
                    for (int k = 0; k < TANKS; k++)
                        if (IW'(k) >= r_nb) r_tank[k] <= w_up[k];
                end
                rlb_pkg::OP_REL4: begin
                    for (int k = 0; k < TANKS; k++)
                        if (IW'(k) > r_nxt) r_tank[k] <= w_dn[k];
                        else if (IW'(k) == r_nxt) r_tank[k] <= '0;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            rlb_pkg::OP_LOAD: begin
                r_p     <= i_tank_index;
                r_moved <= '0;
                r_ex    <= '0;
                r_lc    <= '0;
                r_j     <= '0;
            end
            rlb_pkg::OP_MOD: begin
                if (!o_status.p_ok) r_p <= r_p - rlb_pkg::IDX_BITS'(TANKS);
            end
            rlb_pkg::OP_COPY: begin
                for (int k = 0; k < TANKS; k++)
                    r_scr[k] <= r_tank[k];
                r_a <= w_p;
            end
            rlb_pkg::OP_WAVE: begin
                r_scr[r_a]  <= (r_tank[r_a] >= w_mv) ? r_tank[r_a] - w_mv : '0;
                r_scr[w_wb] <= w_nb_val;
                r_b         <= w_wb;
            end
            rlb_pkg::OP_WAVE_END: begin
                r_ex <= w_ex;
                r_lc <= r_lc + 1'b1;
                r_a  <= r_b;
            end
            rlb_pkg::OP_MIN_INIT, rlb_pkg::OP_MM_INIT: begin
                r_k  <= IW'(1);
                r_mi <= '0;
                r_mx <= r_tank[0];
                r_mn <= r_tank[0];
            end
            rlb_pkg::OP_MIN_STEP: begin
                if (r_tank[r_k] < r_tank[r_mi]) r_mi <= r_k;
                r_k <= IW'(r_k + 1'b1);
            end
            rlb_pkg::OP_REM_INIT: begin
                r_acc <= AW'(r_tank[r_mi]);
                r_c   <= f_inc(r_mi);
            end
            rlb_pkg::OP_REM_STEP: begin
                r_acc <= r_acc + AW'(r_tank[r_c]);
                r_c   <= f_inc(r_c);
                r_j   <= r_j + 1'b1;
            end
            rlb_pkg::OP_SHED_INIT: begin
                r_s <= w_p;
                r_i <= '0;
            end
            rlb_pkg::OP_SHED_STEP: begin
                if (r_tank[w_from] >= w_amt) r_moved <= f_cost(r_moved, w_amt);
                r_s <= f_inc(r_s);
                r_i <= r_i + 1'b1;
            end
            rlb_pkg::OP_AMT: r_amt <= w_div_q;
            rlb_pkg::OP_REL_INIT: begin
                r_far <= f_inc(r_mi);
                r_i   <= '0;
            end
            rlb_pkg::OP_REL0: begin
                r_v  <= r_tank[r_far];
                r_nb <= (r_far == '0) ? IW'(TANKS - 2) : IW'(r_far - 1'b1);
            end
            rlb_pkg::OP_REL1: r_moved <= f_cost(r_moved, r_v);
            rlb_pkg::OP_REL2: begin
                if (r_tank[w_from] >= w_amt) r_moved <= f_cost(r_moved, w_amt);
            end
            rlb_pkg::OP_REL3: begin
                r_dest <= w_dest2;
                r_nxt  <= f_inc(w_dest2);
            end
            rlb_pkg::OP_REL5: begin
                if (r_tank[w_from] >= w_amt) r_moved <= f_cost(r_moved, w_amt);
                r_far <= f_inc(r_far);
                r_i   <= r_i + 1'b1;
            end
            rlb_pkg::OP_MM_STEP: begin
                if (r_tank[r_k] > r_mx) r_mx <= r_tank[r_k];
                if (r_tank[r_k] < r_mn) r_mn <= r_tank[r_k];
                r_k <= IW'(r_k + 1'b1);
            end
            rlb_pkg::OP_OUT: begin
                // hold the result apart from the scan registers of the next step
                r_cost <= f_cost(r_moved, W'(1));
                r_omx  <= r_mx;
                r_omn  <= r_mn;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.p_ok     = {1'b0, r_p} < (rlb_pkg::IDX_BITS+1)'(TANKS);
        o_status.wave_go  = (r_lc <= NB'(r_hop)) && (r_ex <= NB'(r_hop));
        o_status.ex_nz    = r_ex != '0;
        o_status.k_last   = r_k == IW'(TANKS - 1);
        o_status.rem_go   = (r_acc <= AW'(r_scr[f_inc(r_a)])) && (r_j <= r_ex)
                            && (r_j <= NB'(r_hop));
        o_status.shed_go  = r_i <= r_lc;
        o_status.rn_nz    = r_j != '0;
        o_status.rel_go   = r_i <= r_j;
        o_status.div_done = w_div_done;
        o_status.out_free = !r_ov || i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_step_cost = r_cost;
    assign o_max_load  = rlb_pkg::OUT_BITS'(r_omx);
    assign o_min_load  = rlb_pkg::OUT_BITS'(r_omn);
endmodule
`default_nettype wire

/* hdl/rlb_ctrl.sv */
// Controller of the ring load balancer: sequences one step through the
// datapath by rlb_pkg::t_op commands. Depends on rlb_pkg.
`default_nettype none
module rlb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire rlb_pkg::t_status i_status,
    output rlb_pkg::t_cmd         o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_MOD, S_ADD, S_COPY, S_WAVE_CHK, S_WAVE, S_WAVE_WAIT,
        S_REM_CHK, S_MIN_INIT, S_MIN, S_REM_INIT, S_REM, S_SHED_INIT, S_SHED,
        S_DIV, S_DIV_WAIT, S_REL_INIT, S_REL_CHK, S_REL0, S_REL1, S_REL2,
        S_REL3, S_REL4, S_REL5, S_MM_INIT, S_MM, S_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:      if (i_in_valid) r_state <= S_MOD;
                S_MOD:       if (i_status.p_ok) r_state <= S_ADD;
                S_ADD:       r_state <= S_COPY;
                S_COPY:      r_state <= S_WAVE_CHK;
                S_WAVE_CHK:  r_state <= i_status.wave_go ? S_WAVE : S_REM_CHK;
                S_WAVE:      r_state <= S_WAVE_WAIT;
                S_WAVE_WAIT: if (i_status.div_done) r_state <= S_WAVE_CHK;
                S_REM_CHK:   r_state <= i_status.ex_nz ? S_MIN_INIT : S_SHED_INIT;
                S_MIN_INIT:  r_state <= S_MIN;
                S_MIN:       if (i_status.k_last) r_state <= S_REM_INIT;
                S_REM_INIT:  r_state <= S_REM;
                S_REM:       if (!i_status.rem_go) r_state <= S_SHED_INIT;
                S_SHED_INIT: r_state <= S_SHED;
                S_SHED: begin
                    if (!i_status.shed_go)
                        r_state <= i_status.rn_nz ? S_DIV : S_MM_INIT;
                end
                S_DIV:       r_state <= S_DIV_WAIT;
                S_DIV_WAIT:  if (i_status.div_done) r_state <= S_REL_INIT;
                S_REL_INIT:  r_state <= S_REL_CHK;
                S_REL_CHK:   r_state <= i_status.rel_go ? S_REL0 : S_MM_INIT;
                S_REL0:      r_state <= S_REL1;
                S_REL1:      r_state <= S_REL2;
                S_REL2:      r_state <= S_REL3;
                S_REL3:      r_state <= S_REL4;
                S_REL4:      r_state <= S_REL5;
                S_REL5:      r_state <= S_REL_CHK;
                S_MM_INIT:   r_state <= S_MM;
                S_MM:        if (i_status.k_last) r_state <= S_OUT;
                S_OUT:       if (i_status.out_free) r_state <= S_IDLE;
                default:     r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.op = rlb_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) o_cmd.op = rlb_pkg::OP_LOAD;
            S_MOD:       o_cmd.op = rlb_pkg::OP_MOD;
            S_ADD:       o_cmd.op = rlb_pkg::OP_ADD;
            S_COPY:      o_cmd.op = rlb_pkg::OP_COPY;
            S_WAVE:      o_cmd.op = rlb_pkg::OP_WAVE;
            S_WAVE_WAIT: if (i_status.div_done) o_cmd.op = rlb_pkg::OP_WAVE_END;
            S_MIN_INIT:  o_cmd.op = rlb_pkg::OP_MIN_INIT;
            S_MIN:       o_cmd.op = rlb_pkg::OP_MIN_STEP;
            S_REM_INIT:  o_cmd.op = rlb_pkg::OP_REM_INIT;
            S_REM:       if (i_status.rem_go) o_cmd.op = rlb_pkg::OP_REM_STEP;
            S_SHED_INIT: o_cmd.op = rlb_pkg::OP_SHED_INIT;
            S_SHED:      if (i_status.shed_go) o_cmd.op = rlb_pkg::OP_SHED_STEP;
            S_DIV:       o_cmd.op = rlb_pkg::OP_DIV;
            S_DIV_WAIT:  if (i_status.div_done) o_cmd.op = rlb_pkg::OP_AMT;
            S_REL_INIT:  o_cmd.op = rlb_pkg::OP_REL_INIT;
            S_REL0:      o_cmd.op = rlb_pkg::OP_REL0;
            S_REL1:      o_cmd.op = rlb_pkg::OP_REL1;
            S_REL2:      o_cmd.op = rlb_pkg::OP_REL2;
            S_REL3:      o_cmd.op = rlb_pkg::OP_REL3;
            S_REL4:      o_cmd.op = rlb_pkg::OP_REL4;
            S_REL5:      o_cmd.op = rlb_pkg::OP_REL5;
            S_MM_INIT:   o_cmd.op = rlb_pkg::OP_MM_INIT;
            S_MM:        o_cmd.op = rlb_pkg::OP_MM_STEP;
            S_OUT:       if (i_status.out_free) o_cmd.op = rlb_pkg::OP_OUT;
            default:     o_cmd.op = rlb_pkg::OP_NONE;
        endcase
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule
`default_nettype wire

/* hdl/ring_load_balancer.sv */
// Top level of the ring load balancer: controller plus datapath.
// Depends on rlb_pkg, rlb_ctrl, rlb_datapath and assert_macros.svh.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  in      | i_in_valid / o_in_ready   | i_tank_index
//  out     | o_out_valid / i_out_ready | o_step_cost, o_max_load, o_min_load
//  cfg     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One item at a time: index reduction, then local hops (at most hop_limit+1 hops,
// mostly a divider pass each), a minimum scan, remote and shed passes and, if tanks
// are to be relocated, one more divider pass and a relocation sequence (REL0 to
// REL5) per relocated tank, then a max/min scan.
// Synchronous reset clears all loads.
// A result waits in the output register while the next step runs.
`default_nettype none
`include "assert_macros.svh"
module ring_load_balancer #(
    parameter int TANKS     = rlb_pkg::TANKS_DEF,
    parameter int LOAD_BITS = rlb_pkg::LOAD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [rlb_pkg::IDX_BITS-1:0]      i_tank_index,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [rlb_pkg::COST_BITS-1:0]          o_step_cost,
    output logic [rlb_pkg::OUT_BITS-1:0]           o_max_load,
    output logic [rlb_pkg::OUT_BITS-1:0]           o_min_load,
    input  wire logic                              i_cfg_we,
    input  wire logic [rlb_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [rlb_pkg::CFG_BITS-1:0]      i_cfg_data
);
    rlb_pkg::t_cmd    w_cmd;
    rlb_pkg::t_status w_status;

    rlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rlb_datapath #(
        .TANKS     (TANKS),
        .LOAD_BITS (LOAD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_tank_index (i_tank_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_step_cost  (o_step_cost),
        .o_max_load   (o_max_load),
        .o_min_load   (o_min_load)
    );

    // a transfer in starts a step, so no second one follows directly
    `RLB_ASSERT_NXT(a_one_step, i_in_valid && o_in_ready, !o_in_ready)
    // never overwrite a result that is still waiting
    `RLB_ASSERT_IMP(a_no_overwrite, w_cmd.op == rlb_pkg::OP_OUT, !o_out_valid || i_out_ready)
    `RLB_ASSERT_IMP(a_min_le_max, o_out_valid, o_min_load <= o_max_load)
endmodule
`default_nettype wire
